// ===== rtl/core/pal_pkg.sv =====
// pal_pkg: shared types and constants for the positional array list
// operation and status codes, cell command struct, control state enum
// no dependencies
package pal_pkg;

    // operation codes on s_opcode
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    // status codes on m_status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // most words one dump may emit
    localparam int MAX_RESULTS = 16;

    // width of the position broadcast to the cells, covers capacity up to 128
    localparam int PAL_CMD_W = 7;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [PAL_CMD_W-1:0]   pos;
    } cell_cmd_t;

    typedef enum logic [0:0] {
        PAL_IDLE,
        PAL_DUMP
    } pal_state_t;

endpackage

// ===== rtl/core/pal_cell.sv =====
// pal_cell: one storage cell of the list chain
// takes its left or right neighbor, the new value or the head value per command
// depends on pal_pkg
module pal_cell #(
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  pal_pkg::cell_cmd_t  cmd,
    input  logic [31:0]         data_in,
    input  logic [31:0]         left_data,
    input  logic [31:0]         right_data,
    input  logic [31:0]         head_data,
    output logic [31:0]         q
);
    import pal_pkg::*;

    localparam logic [PAL_CMD_W-1:0] IDX = PAL_CMD_W'(INDEX);

    logic [31:0] q_reg;
    logic [31:0] q_next;

    always_comb begin
        q_next = q_reg;
        case (cmd.op)
            CELL_APPEND: begin
                if (IDX == cmd.pos) q_next = data_in;
            end
            CELL_INSERT: begin
                if (IDX > cmd.pos) q_next = left_data;
                else if (IDX == cmd.pos) q_next = data_in;
            end
            CELL_REMOVE: begin
                if (IDX >= cmd.pos) q_next = right_data;
            end
            CELL_ROTATE: begin
                // pos carries the tail index here
                if (IDX < cmd.pos) q_next = right_data;
                else if (IDX == cmd.pos) q_next = head_data;
            end
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/positional_array_list.sv =====
// positional_array_list: ordered list of signed 32-bit words in a chain of cells
// append, insert and remove give one result word each; ready again once the result slot is free
// dump holds the input through the accept, then count rotations of the chain
// each rotation up to the word limit registers the head cell as one word; a waiting word stalls it
// reset (aresetn low, synchronous) empties the list and drops any pending result
// depends on pal_pkg and pal_cell
module positional_array_list #(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [4:0]         s_position_in,
    input  logic signed [31:0] s_data_in,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [4:0]         m_element_count,
    output logic [3:0]         m_position_out,
    output logic signed [31:0] m_data_out,
    output logic               m_entry_valid,
    output logic               m_last
);
    import pal_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    // compare width, wide enough for count, position_in and the dump limit
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_RESULTS);

    // control state
    pal_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   dump_idx_reg, dump_idx_next;
    logic [CMP_W-1:0]   emit_last_reg, emit_last_next;   // index of the last emitted word

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [4:0]         m_count_reg, m_count_next;
    logic [3:0]         m_pos_reg, m_pos_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic               m_entry_valid_reg, m_entry_valid_next;
    logic               m_last_reg, m_last_next;

    logic               slot_free;
    logic               in_fire;
    logic               dump_emit;
    logic               dump_step;
    logic               op_result;
    logic [1:0]         res_status;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   tail_idx;
    logic               dump_done;
    cell_cmd_t          cmd;
    logic [31:0]        cell_q [CAPACITY];

    assign slot_free = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(s_position_in);
    assign idx_ext   = CMP_W'(dump_idx_reg);
    assign tail_idx  = count_reg - CNT_W'(1);
    assign dump_done = (dump_idx_reg == tail_idx);

    // ---------------------------------------------------------------
    // chain of cells: cell 0 is the list head
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
        logic [31:0] left_w;
        logic [31:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = s_data_in;
        end else begin : g_mid_l
            assign left_w = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_lastc
            assign right_w = cell_q[i];
        end else begin : g_mid_r
            assign right_w = cell_q[i+1];
        end
        pal_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .data_in    (s_data_in),
            .left_data  (left_w),
            .right_data (right_w),
            .head_data  (cell_q[0]),
            .q          (cell_q[i])
        );
    end

    // ---------------------------------------------------------------
    // operation decode: range and full checks, cell command, new count
    // ---------------------------------------------------------------
    always_comb begin
        res_status = ST_OK;
        count_next = count_reg;
        cmd.op     = CELL_HOLD;
        cmd.pos    = '0;
        if (in_fire) begin
            case (s_opcode)
                OP_APPEND: begin
                    if (count_reg == CAP_C) begin
                        res_status = ST_FULL;
                    end else begin
                        cmd.op     = CELL_APPEND;
                        cmd.pos    = PAL_CMD_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_INSERT: begin
                    // range check wins over full
                    if (pos_ext > count_ext) begin
                        res_status = ST_RANGE;
                    end else if (count_reg == CAP_C) begin
                        res_status = ST_FULL;
                    end else begin
                        cmd.op     = CELL_INSERT;
                        cmd.pos    = PAL_CMD_W'(s_position_in);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (pos_ext >= count_ext) begin
                        res_status = ST_RANGE;
                    end else begin
                        cmd.op     = CELL_REMOVE;
                        cmd.pos    = PAL_CMD_W'(s_position_in);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    // dump leaves the store alone at accept time
                    res_status = ST_OK;
                end
            endcase
        end else if (dump_step) begin
            // rotate the live part of the chain one place toward the head
            cmd.op  = CELL_ROTATE;
            cmd.pos = PAL_CMD_W'(tail_idx);
        end
    end

    // ---------------------------------------------------------------
    // state machine: next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PAL_IDLE: begin
                if (in_fire && s_opcode == OP_DUMP && count_reg != '0) state_next = PAL_DUMP;
            end
            PAL_DUMP: begin
                if (dump_step && dump_done) state_next = PAL_IDLE;
            end
            default: state_next = PAL_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        s_ready   = 1'b0;
        dump_emit = 1'b0;
        dump_step = 1'b0;
        case (state_reg)
            PAL_IDLE: begin
                s_ready = slot_free;
            end
            PAL_DUMP: begin
                // past the word limit the chain keeps rotating without output
                dump_emit = (idx_ext <= emit_last_reg);
                dump_step = !dump_emit || slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // dump index and emit limit
    always_comb begin
        dump_idx_next  = dump_idx_reg;
        emit_last_next = emit_last_reg;
        if (in_fire) begin
            dump_idx_next  = '0;
            emit_last_next = (count_ext > MAX_C) ? (MAX_C - CMP_W'(1))
                                                 : (count_ext - CMP_W'(1));
        end else if (dump_step) begin
            dump_idx_next = dump_idx_reg + CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // result word register
    // ---------------------------------------------------------------
    assign op_result = in_fire && (s_opcode != OP_DUMP || count_reg == '0);

    always_comb begin
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_count_next       = m_count_reg;
        m_pos_next         = m_pos_reg;
        m_data_next        = m_data_reg;
        m_entry_valid_next = m_entry_valid_reg;
        m_last_next        = m_last_reg;
        if (op_result) begin
            // status word, also the lone word of an empty dump
            m_valid_next       = 1'b1;
            m_status_next      = res_status;
            m_count_next       = 5'(count_next);
            m_pos_next         = '0;
            m_data_next        = '0;
            m_entry_valid_next = 1'b0;
            m_last_next        = 1'b1;
        end else if (dump_step && dump_emit) begin
            m_valid_next       = 1'b1;
            m_status_next      = ST_OK;
            m_count_next       = 5'(count_reg);
            m_pos_next         = 4'(dump_idx_reg);
            m_data_next        = cell_q[0];
            m_entry_valid_next = 1'b1;
            m_last_next        = (idx_ext == emit_last_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PAL_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_idx_reg      <= dump_idx_next;
        emit_last_reg     <= emit_last_next;
        m_status_reg      <= m_status_next;
        m_count_reg       <= m_count_next;
        m_pos_reg         <= m_pos_next;
        m_data_reg        <= m_data_next;
        m_entry_valid_reg <= m_entry_valid_next;
        m_last_reg        <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_element_count = m_count_reg;
    assign m_position_out  = m_pos_reg;
    assign m_data_out      = m_data_reg;
    assign m_entry_valid   = m_entry_valid_reg;
    assign m_last          = m_last_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("list count above capacity");

    // the list does not change size during a dump
    a_dump_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PAL_DUMP |=> $stable(count_reg))
        else $error("count changed during dump");

    // the rotation index stays inside the live entries
    a_dump_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PAL_DUMP |-> dump_idx_reg < count_reg)
        else $error("dump index past list end");

    // a dumped word always reports ok status
    a_dump_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_entry_valid_reg |-> m_status_reg == ST_OK)
        else $error("dumped word with bad status");

endmodule
